### design/lmc_pkg.sv
// shared types and constants for the local maxima counter
// no dependencies

package lmc_pkg;

  localparam int TOTAL_W    = 21;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [TOTAL_W-1:0]   TOTAL_MAX        = {TOTAL_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  // control from the top level to the line of cells
  typedef struct packed {
    logic shift;
    logic clear_head;
  } lmc_line_ctrl_t;

  // control from the line to one cell
  typedef struct packed {
    logic load;
    logic inject;
    logic clear;
  } lmc_cell_ctrl_t;

endpackage

### design/lmc_cell.sv
// one cell of the line store: a value and its candidate flag (bit 0)
// depends on lmc_pkg

module lmc_cell
  import lmc_pkg::*;
#(
  parameter int ENTRY_W = 17
) (
  input  logic               clk,
  input  lmc_cell_ctrl_t     ctrl,
  input  logic [ENTRY_W-1:0] nbr_entry,
  input  logic [ENTRY_W-1:0] ins_entry,
  output logic [ENTRY_W-1:0] entry
);

  logic [ENTRY_W-1:0] entry_r;
  logic [ENTRY_W-1:0] entry_nxt;
  logic [ENTRY_W-1:0] pick;

  always_comb begin
    pick      = ctrl.inject ? ins_entry : nbr_entry;
    entry_nxt = {pick[ENTRY_W-1:1], pick[0] & ~ctrl.clear};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;

endmodule

### design/lmc_line.sv
// programmable-length line of cells holding the row above
// entries enter at the cell set by the column count and leave at cell 0
// depends on lmc_pkg, lmc_cell

module lmc_line
  import lmc_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int ENTRY_W     = 17,
  parameter int COL_W       = 10
) (
  input  logic               clk,
  input  lmc_line_ctrl_t     ctrl,
  input  logic [COL_W-1:0]   last_col,
  input  logic [ENTRY_W-1:0] ins_entry,
  output logic [ENTRY_W-1:0] head0,
  output logic [ENTRY_W-1:0] head1
);

  localparam int CHAIN = (MAX_COLUMNS > 1) ? MAX_COLUMNS - 1 : 1;

  logic [ENTRY_W-1:0] cells [CHAIN];

  genvar k;
  generate
    for (k = 0; k < CHAIN; k++) begin : g_cell
      lmc_cell_ctrl_t     cc;
      logic [ENTRY_W-1:0] nbr;
      logic               inj;

      assign inj = (last_col == COL_W'(k + 1));

      if (k == CHAIN - 1) begin : g_tail
        assign nbr = ins_entry;
      end else begin : g_mid
        assign nbr = cells[k + 1];
      end

      if (k == 0) begin : g_head
        assign cc.clear = ctrl.clear_head & ~inj;
      end else begin : g_body
        assign cc.clear = 1'b0;
      end

      assign cc.load   = ctrl.shift;
      assign cc.inject = inj;

      lmc_cell #(
        .ENTRY_W (ENTRY_W)
      ) u_cell (
        .clk       (clk),
        .ctrl      (cc),
        .nbr_entry (nbr),
        .ins_entry (ins_entry),
        .entry     (cells[k])
      );
    end

    if (CHAIN > 1) begin : g_h1
      assign head1 = cells[1];
    end else begin : g_h1_none
      assign head1 = cells[0];
    end
  endgenerate

  assign head0 = cells[0];

endmodule

### design/local_maxima_counter_3x3_top.sv
// top level of the strict eight-neighbor local maxima counter
// depends on lmc_pkg, lmc_line, lmc_cell
//
// usage:
//   in_*   : one matrix value per item, raster order, in_tdata[VALUE_BITS-1:0]
//   out_*  : one item per frame, out_tdata[20:0] = maxima_total
//   cfg_*  : index 0 = row_count, index 1 = column_count (zero reads as one,
//            larger than the maximum saturates); a write to either restarts the frame
// throughput: one item per cycle unless the stall below holds the input, set by
//   the line of cells that shifts the row above by one cell each accepted item
//   and by combinational neighbor compares
// latency: the count appears in the output register the cycle after the
//   final value of a frame is accepted
// reset: sizes return to 1x1, position and total clear; the line of cells
//   needs no clearing, the first row of a frame refills it
// stall: a waiting count holds the input only when the next item would end
//   another frame; otherwise input keeps flowing

module local_maxima_counter_3x3_top
  import lmc_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int VALUE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0] in_tdata,   // cell_value
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_TDATA_W-1:0]        out_tdata,  // maxima_total
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ENTRY_W = VALUE_BITS + 1;
  localparam int CMP_W   = 13;

  logic [COL_W-1:0]   last_col_r, last_col_nxt;
  logic [ROW_W-1:0]   last_row_r, last_row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0] out_data_r, out_data_nxt;
  logic [ENTRY_W-1:0] left_r, left_nxt;
  logic [ENTRY_W-1:0] ul_r, ul_nxt;

  logic [ENTRY_W-1:0] head0, head1, ins_entry;
  lmc_line_ctrl_t     line_ctrl;

  logic                         fire, cfg_fire, final_pos;
  logic                         have_up, have_left, have_right, last_row_hit, last_col_hit;
  logic                         len1, len2, ur_from_left;
  logic signed [VALUE_BITS-1:0] v, left_v, ul_v, up_v, ur_v;
  logic                         left_f, ul_f, up_f;
  logic [ENTRY_W-1:0]           up_e, ur_e;
  logic                         own, up_flag_n, ul_flag_n, left_flag_n, ur_clear;
  logic [2:0]                   inc;
  logic [TOTAL_W:0]             sum;
  logic [TOTAL_W-1:0]           sat_sum;
  logic [CMP_W-1:0]             cfg_wide;

  assign fire      = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign final_pos = (row_r == last_row_r) && (col_r == last_col_r);
  assign in_tready = ~(out_valid_r & ~out_tready & final_pos);

  always_comb begin
    have_up      = (row_r != '0);
    have_left    = (col_r != '0);
    have_right   = (col_r != last_col_r);
    last_row_hit = (row_r == last_row_r);
    last_col_hit = (col_r == last_col_r);
    len1         = (last_col_r == '0);
    len2         = (last_col_r == COL_W'(1));
    ur_from_left = len2 && (col_r == '0);

    v      = $signed(in_tdata[VALUE_BITS-1:0]);
    up_e   = len1 ? left_r : head0;
    ur_e   = ur_from_left ? left_r : head1;
    left_v = $signed(left_r[ENTRY_W-1:1]);
    left_f = left_r[0];
    ul_v   = $signed(ul_r[ENTRY_W-1:1]);
    ul_f   = ul_r[0];
    up_v   = $signed(up_e[ENTRY_W-1:1]);
    up_f   = up_e[0];
    ur_v   = $signed(ur_e[ENTRY_W-1:1]);

    own = ~(have_left && (left_v >= v)) &&
          ~(have_up && (up_v >= v)) &&
          ~(have_up && have_left && (ul_v >= v)) &&
          ~(have_up && have_right && (ur_v >= v));

    ur_clear    = have_up && have_right && (v >= ur_v);
    up_flag_n   = up_f & ~(have_up && (v >= up_v));
    ul_flag_n   = ul_f & ~(have_up && have_left && (v >= ul_v));
    left_flag_n = left_f & ~(have_left && (v >= left_v)) & ~(ur_clear && ur_from_left);

    inc = 3'(have_up && have_left && ul_flag_n) +
          3'(have_up && last_col_hit && up_flag_n) +
          3'(last_row_hit && have_left && left_flag_n) +
          3'(last_row_hit && last_col_hit && own);
    sum     = {1'b0, total_r} + (TOTAL_W + 1)'(inc);
    sat_sum = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

    ins_entry            = {left_r[ENTRY_W-1:1], left_flag_n};
    line_ctrl.shift      = fire;
    line_ctrl.clear_head = ur_clear && ~ur_from_left;
  end

  always_comb begin
    last_col_nxt  = last_col_r;
    last_row_nxt  = last_row_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    left_nxt      = left_r;
    ul_nxt        = ul_r;
    cfg_wide      = {{(CMP_W-CFG_DATA_W){1'b0}}, cfg_data};

    if (fire) begin
      left_nxt = {v, own};
      ul_nxt   = {up_e[ENTRY_W-1:1], up_flag_n};
      if (!last_col_hit) begin
        col_nxt   = col_r + COL_W'(1);
        total_nxt = sat_sum;
      end else if (!last_row_hit) begin
        col_nxt   = '0;
        row_nxt   = row_r + ROW_W'(1);
        total_nxt = sat_sum;
      end else begin
        col_nxt       = '0;
        row_nxt       = '0;
        total_nxt     = '0;
        out_valid_nxt = 1'b1;
        out_data_nxt  = sat_sum;
      end
    end

    if (cfg_fire) begin
      case (cfg_index)
        REG_ROW_COUNT: begin
          if (cfg_wide == '0) begin
            last_row_nxt = '0;
          end else if (cfg_wide > CMP_W'(MAX_ROWS)) begin
            last_row_nxt = ROW_W'(MAX_ROWS - 1);
          end else begin
            last_row_nxt = ROW_W'(cfg_wide - CMP_W'(1));
          end
          col_nxt   = '0;
          row_nxt   = '0;
          total_nxt = '0;
        end
        REG_COLUMN_COUNT: begin
          if (cfg_wide == '0) begin
            last_col_nxt = '0;
          end else if (cfg_wide > CMP_W'(MAX_COLUMNS)) begin
            last_col_nxt = COL_W'(MAX_COLUMNS - 1);
          end else begin
            last_col_nxt = COL_W'(cfg_wide - CMP_W'(1));
          end
          col_nxt   = '0;
          row_nxt   = '0;
          total_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r  <= '0;
      last_row_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      last_col_r  <= last_col_nxt;
      last_row_r  <= last_row_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    left_r     <= left_nxt;
    ul_r       <= ul_nxt;
  end

  lmc_line #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .ENTRY_W     (ENTRY_W),
    .COL_W       (COL_W)
  ) u_line (
    .clk       (clk),
    .ctrl      (line_ctrl),
    .last_col  (last_col_r),
    .ins_entry (ins_entry),
    .head0     (head0),
    .head1     (head1)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-TOTAL_W){1'b0}}, out_data_r};

endmodule
